/* hdl/pipw_pkg.sv */
// ---------------------------------------------------------------------------
// pipw_pkg: shared definitions for the winding-number point-in-polygon block
// Command codes, default sizes and the control and status groups that pass
// between the sequencer and the edge arithmetic unit.
// ---------------------------------------------------------------------------
package pipw_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_COORD_BITS   = 24;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Sequencer to edge unit.
    typedef struct packed {
        logic load_diff;
        logic mul_p;
        logic mul_q;
    } t_unit_ctl;

    // Edge unit to sequencer: sign of the cross product.
    typedef struct packed {
        logic pos;
        logic neg;
    } t_unit_sts;

endpackage

/* hdl/pipw_edge_unit.sv */
// ---------------------------------------------------------------------------
// pipw_edge_unit: exact cross-product sign for one polygon edge
// Forms the coordinate differences, then uses a single multiplier twice to
// build both products, and reports the sign of their difference.
// ---------------------------------------------------------------------------
module pipw_edge_unit
    import pipw_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  t_unit_ctl                    i_ctl,
    input  logic signed [COORD_BITS-1:0] i_x0,
    input  logic signed [COORD_BITS-1:0] i_y0,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output t_unit_sts                    o_sts
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW = PW + 1;

    logic signed [DW-1:0] r_dx, r_dyp, r_dxp, r_dy;
    logic signed [PW-1:0] r_p, r_q;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_out;
    logic signed [RW-1:0] diff;

    // The one multiplier is shared by both products of the edge.
    assign mul_a   = i_ctl.mul_q ? r_dxp : r_dx;
    assign mul_b   = i_ctl.mul_q ? r_dy  : r_dyp;
    assign mul_out = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_diff) begin
            r_dx  <= {i_x1[COORD_BITS-1], i_x1} - {i_x0[COORD_BITS-1], i_x0};
            r_dyp <= {i_py[COORD_BITS-1], i_py} - {i_y0[COORD_BITS-1], i_y0};
            r_dxp <= {i_px[COORD_BITS-1], i_px} - {i_x0[COORD_BITS-1], i_x0};
            r_dy  <= {i_y1[COORD_BITS-1], i_y1} - {i_y0[COORD_BITS-1], i_y0};
        end
        if (i_ctl.mul_p) begin
            r_p <= mul_out;
        end
        if (i_ctl.mul_q) begin
            r_q <= mul_out;
        end
    end

    assign diff      = {r_p[PW-1], r_p} - {r_q[PW-1], r_q};
    assign o_sts.neg = diff[RW-1];
    assign o_sts.pos = !diff[RW-1] && (|diff);

endmodule

/* hdl/point_in_polygon_winding.sv */
// Clear and append commands, and a query on an empty polygon, leave busy low:
// the result beat is registered on the accepting edge and shows in the cycle after.
// A query over stored vertices holds busy high while each edge runs FETCH, DIFF, MUL1, MUL2, ACC;
// the single shared multiplier forms two products per edge; the beat follows as busy drops.
// Reset (synchronous, active low) empties the polygon and idles the sequencer.
// The receiver cannot stall; each result beat lasts exactly one cycle.
// ---------------------------------------------------------------------------
// point_in_polygon_winding: winding-number point-in-polygon test
// Stores a polygon's vertices and, on a query, walks every edge including
// the closing one, accumulating the signed winding number of the point.
// ---------------------------------------------------------------------------
module point_in_polygon_winding
    import pipw_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS,
    localparam int IW          = $clog2(MAX_VERTICES),
    localparam int CW          = $clog2(MAX_VERTICES + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_command,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_valid,
    output logic                         o_inside_res,
    output logic signed [CW:0]           o_winding,
    output logic [CW-1:0]                o_count,
    output logic                         o_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DIFF  = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_idx;
    logic                         r_valid, r_inside, r_status;
    logic signed [CW:0]           r_wn, n_wn;
    logic signed [COORD_BITS-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic                         r_up, r_dn;
    logic                         accept, last_edge, is_full, mem_wr;
    t_unit_ctl                    ctl;
    t_unit_sts                    sts;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign is_full   = (r_count >= CW'(MAX_VERTICES));
    assign last_edge = (r_idx == r_count);
    assign mem_wr    = accept && (i_command == CMD_APPEND) && !is_full;

    // Past the last vertex the walk closes back onto the first one.
    assign cur_x = last_edge ? r_first_x : r_rd_x;
    assign cur_y = last_edge ? r_first_y : r_rd_y;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem_x[r_count[IW-1:0]] <= i_coord_x;
            r_mem_y[r_count[IW-1:0]] <= i_coord_y;
        end
        r_rd_x <= r_mem_x[r_idx[IW-1:0]];
        r_rd_y <= r_mem_y[r_idx[IW-1:0]];
    end

    assign ctl.load_diff = (r_state == S_DIFF) && (r_idx != '0);
    assign ctl.mul_p     = (r_state == S_MUL1);
    assign ctl.mul_q     = (r_state == S_MUL2);

    pipw_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_x0  (r_prev_x),
        .i_y0  (r_prev_y),
        .i_x1  (cur_x),
        .i_y1  (cur_y),
        .i_px  (r_px),
        .i_py  (r_py),
        .o_sts (sts)
    );

    always_comb begin
        n_wn = r_wn;
        if (r_up && sts.pos) begin
            n_wn = r_wn + (CW+1)'(1);
        end else if (r_dn && sts.neg) begin
            n_wn = r_wn - (CW+1)'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_QUERY) && (r_count != '0)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_DIFF;
            S_DIFF:  n_state = (r_idx == '0) ? S_FETCH : S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ACC;
            S_ACC:   n_state = last_edge ? S_IDLE : S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (i_command)
                    CMD_CLEAR:  r_count <= '0;
                    CMD_APPEND: if (!is_full) r_count <= r_count + CW'(1);
                    default:    ;
                endcase
            end
            r_valid <= (accept && ((i_command != CMD_QUERY) || (r_count == '0))) ||
                       ((r_state == S_ACC) && last_edge);
        end
    end

    // Walk and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx    <= '0;
            r_wn     <= '0;
            r_inside <= 1'b0;
            r_status <= (i_command == CMD_APPEND) && is_full;
            r_px     <= i_coord_x;
            r_py     <= i_coord_y;
        end
        if (r_state == S_DIFF) begin
            if (r_idx == '0) begin
                r_first_x <= cur_x;
                r_first_y <= cur_y;
                r_idx     <= CW'(1);
            end
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
            r_up     <= (r_prev_y <= r_py) && (cur_y > r_py);
            r_dn     <= (r_prev_y > r_py) && (cur_y <= r_py);
        end
        if (r_state == S_ACC) begin
            r_wn <= n_wn;
            if (last_edge) begin
                r_inside <= (n_wn != '0);
            end else begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;
    assign o_winding    = r_wn;
    assign o_count      = r_count;
    assign o_status     = r_status;

endmodule

/* hdl/pipw_checker.sv */
// ---------------------------------------------------------------------------
// pipw_checker: port-level checks for the point-in-polygon block
// Watches the command and result ports over time; bound to the top level.
// ---------------------------------------------------------------------------
module pipw_checker
    import pipw_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int CW          = $clog2(MAX_VERTICES + 1)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_command,
    input logic                         o_valid,
    input logic                         o_inside_res,
    input logic signed [CW:0]           o_winding,
    input logic [CW-1:0]                o_count,
    input logic                         o_status
);

    // A result beat only ever appears once the sequencer has gone idle.
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // Clear and append answer in the very next cycle.
    a_load_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command != CMD_QUERY)) |=> (o_valid && !busy))
        else $error("load command gave no beat next cycle");

    // The inside flag agrees with the winding number.
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_inside_res == (o_winding != '0)))
        else $error("inside flag disagrees with winding");

    // A dropped vertex is reported only with a full store.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_count == CW'(MAX_VERTICES)))
        else $error("drop reported with room in the store");

endmodule

bind point_in_polygon_winding pipw_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_pipw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_command    (i_command),
    .o_valid      (o_valid),
    .o_inside_res (o_inside_res),
    .o_winding    (o_winding),
    .o_count      (o_count),
    .o_status     (o_status)
);
